FILE: rtl/bsrk_pkg.sv
package bsrk_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 16;
  localparam int COEF_BITS      = 15;

  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int ROW_WIDTH_BITS = 11;
  localparam int ROWS_BITS      = 16;
  // row counter must reach rows_in_use + 1
  localparam int ROW_CNT_BITS   = ROWS_BITS + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ADV_ROW     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIFF_ROW    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ADV_COL     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIFF_COL    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_IN_USE = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_C,
    ST_RD_S,
    ST_RD_E,
    ST_RD_W,
    ST_HAND
  } seq_state_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pt_flags_t;

  // row index modulo 3: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3_row(input logic [ROW_CNT_BITS-1:0] v);
    logic [ROW_CNT_BITS:0] x;
    logic [4:0] s;
    logic [5:0] y;
    logic [3:0] t;
    x = {1'b0, v};
    s = '0;
    for (int i = 0; i < (ROW_CNT_BITS + 1) / 2; i++) begin
      s = s + 5'(x[2*i +: 2]);
    end
    y = {1'b0, s};
    t = 4'(y[1:0]) + 4'(y[3:2]) + 4'(y[5:4]);
    if (t >= 4'd6) begin
      t = t - 4'd6;
    end else if (t >= 4'd3) begin
      t = t - 4'd3;
    end
    return t[1:0];
  endfunction

endpackage

FILE: rtl/bsrk_ram.sv
module bsrk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bsrk_seq.sv
module bsrk_seq import bsrk_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [2*VALUE_BITS-1:0]   in_vel,
  input  logic [2*VALUE_BITS-1:0]   in_prev,
  input  logic                      frame_start,
  input  logic [ROW_WIDTH_BITS-1:0] row_width,
  input  logic [ROWS_BITS-1:0]      rows_in_use,
  output logic                      op_valid,
  input  logic                      op_ready,
  output logic [2*VALUE_BITS-1:0]   op_ctr,
  output logic [2*VALUE_BITS-1:0]   op_nth,
  output logic [2*VALUE_BITS-1:0]   op_sth,
  output logic [2*VALUE_BITS-1:0]   op_est,
  output logic [2*VALUE_BITS-1:0]   op_wst,
  output logic [2*VALUE_BITS-1:0]   op_prv,
  output pt_flags_t                 op_flags
);

  localparam int PW  = 2 * VALUE_BITS;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int VAW = $clog2(3 * MAX_WIDTH);
  localparam int PAW = $clog2(2 * MAX_WIDTH);
  localparam logic [VAW-1:0] BASE1  = VAW'(MAX_WIDTH);
  localparam logic [VAW-1:0] BASE2  = VAW'(2 * MAX_WIDTH);
  localparam logic [PAW-1:0] PBASE1 = PAW'(MAX_WIDTH);

  seq_state_t state, state_next;

  logic [CW-1:0]           col_cnt;
  logic [ROW_CNT_BITS-1:0] row_cnt;

  logic [WW-1:0]           wd;
  logic [ROWS_BITS-1:0]    nr;
  logic [ROW_CNT_BITS-1:0] last_row, r0, r;
  logic [CW-1:0]           c, east_col, west_col;
  logic [WW-1:0]           cp1;
  logic                    last_col, produce, accept;
  logic [1:0]              slot;
  logic [VAW-1:0]          wr_base, ctr_base, sth_base;
  logic [PAW-1:0]          prv_base, pwr_base;

  logic [VAW-1:0] ctr_addr, sth_addr, est_addr, wst_addr, vraddr;
  logic [PAW-1:0] prv_addr;
  logic [PW-1:0]  nth_q, ctr_q, sth_q, est_q, prv_q;
  logic [PW-1:0]  vrdata, prdata;
  pt_flags_t      flags_q;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // position of the incoming point, with out-of-range settings clamped
  always_comb begin
    if (row_width == '0) begin
      wd = WW'(1);
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      wd = WW'(MAX_WIDTH);
    end else begin
      wd = WW'(row_width);
    end
    nr       = (rows_in_use == '0) ? ROWS_BITS'(1) : rows_in_use;
    last_row = ROW_CNT_BITS'(nr) + ROW_CNT_BITS'(1);
    c        = frame_start ? '0 : col_cnt;
    r0       = frame_start ? '0 : row_cnt;
    r        = (r0 > last_row) ? last_row : r0;
    cp1      = WW'(c) + WW'(1);
    last_col = (cp1 >= wd);
    produce  = (r >= ROW_CNT_BITS'(2));
    east_col = last_col ? '0 : CW'(cp1);
    west_col = (c == '0) ? CW'(wd - WW'(1)) : c - CW'(1);
    slot     = mod3_row(r);
    case (slot)
      2'd0: begin
        wr_base  = '0;
        ctr_base = BASE2;
        sth_base = BASE1;
      end
      2'd1: begin
        wr_base  = BASE1;
        ctr_base = '0;
        sth_base = BASE2;
      end
      default: begin
        wr_base  = BASE2;
        ctr_base = BASE1;
        sth_base = '0;
      end
    endcase
    pwr_base = r[0] ? PBASE1 : '0;
    prv_base = r[0] ? '0 : PBASE1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= (r >= last_row) ? '0 : r + ROW_CNT_BITS'(1);
      end else begin
        col_cnt <= CW'(cp1);
        row_cnt <= r;
      end
    end
  end

  // addresses and flags of the point being worked on
  always_ff @(posedge clk) begin
    if (accept) begin
      ctr_addr          <= ctr_base + VAW'(c);
      sth_addr          <= sth_base + VAW'(c);
      est_addr          <= ctr_base + VAW'(east_col);
      wst_addr          <= ctr_base + VAW'(west_col);
      prv_addr          <= prv_base + PAW'(c);
      nth_q             <= in_vel;
      flags_q.row_end   <= last_col;
      flags_q.frame_end <= last_col && (r == last_row);
    end
  end

  // read data lands in the cycle after its address
  always_ff @(posedge clk) begin
    case (state)
      ST_RD_S: begin
        ctr_q <= vrdata;
        prv_q <= prdata;
      end
      ST_RD_E: sth_q <= vrdata;
      ST_RD_W: est_q <= vrdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op_valid   = 1'b0;
    vraddr     = ctr_addr;
    case (state)
      ST_IDLE: begin
        if (accept && produce) begin
          state_next = ST_RD_C;
        end
      end
      ST_RD_C: state_next = ST_RD_S;
      ST_RD_S: begin
        vraddr     = sth_addr;
        state_next = ST_RD_E;
      end
      ST_RD_E: begin
        vraddr     = est_addr;
        state_next = ST_RD_W;
      end
      ST_RD_W: begin
        vraddr     = wst_addr;
        state_next = ST_HAND;
      end
      ST_HAND: begin
        vraddr   = wst_addr;
        op_valid = 1'b1;
        if (op_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  bsrk_ram #(
    .WIDTH (PW),
    .DEPTH (3 * MAX_WIDTH)
  ) u_vel_lines (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_base + VAW'(c)),
    .wdata (in_vel),
    .raddr (vraddr),
    .rdata (vrdata)
  );

  bsrk_ram #(
    .WIDTH (PW),
    .DEPTH (2 * MAX_WIDTH)
  ) u_prev_lines (
    .clk   (clk),
    .we    (accept),
    .waddr (pwr_base + PAW'(c)),
    .wdata (in_prev),
    .raddr (prv_addr),
    .rdata (prdata)
  );

  assign op_ctr   = ctr_q;
  assign op_nth   = nth_q;
  assign op_sth   = sth_q;
  assign op_est   = est_q;
  assign op_wst   = vrdata;
  assign op_prv   = prv_q;
  assign op_flags = flags_q;

  a_halo_stays_idle: assert property (@(posedge clk) disable iff (rst)
    accept && !produce |=> state == ST_IDLE)
    else $error("halo point started a read sequence");

  a_interior_reads: assert property (@(posedge clk) disable iff (rst)
    accept && produce |=> state == ST_RD_C)
    else $error("interior point did not start its reads");

  a_hand_holds: assert property (@(posedge clk) disable iff (rst)
    state == ST_HAND && !op_ready |=> state == ST_HAND)
    else $error("operands dropped before the datapath took them");

endmodule

FILE: rtl/bsrk_dp.sv
module bsrk_dp import bsrk_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    op_valid,
  output logic                    op_ready,
  input  logic [2*VALUE_BITS-1:0] op_ctr,
  input  logic [2*VALUE_BITS-1:0] op_nth,
  input  logic [2*VALUE_BITS-1:0] op_sth,
  input  logic [2*VALUE_BITS-1:0] op_est,
  input  logic [2*VALUE_BITS-1:0] op_wst,
  input  logic [2*VALUE_BITS-1:0] op_prv,
  input  pt_flags_t               op_flags,
  input  logic [15:0]             adv_row,
  input  logic [15:0]             diff_row,
  input  logic [15:0]             adv_col,
  input  logic [15:0]             diff_col,
  input  logic                    half_weight,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [VALUE_BITS-1:0]   new_row,
  output logic [VALUE_BITS-1:0]   new_col,
  output pt_flags_t               out_flags,
  output logic                    saturated
);

  localparam int V      = VALUE_BITS;
  localparam int F      = V - 4;
  localparam int PRW    = 2 * V + 1;
  localparam int AW     = PRW - F;
  localparam int TW     = 17 + AW;
  localparam int ACCW   = V + 24;
  localparam int RW     = ACCW - COEF_BITS;
  localparam logic [PRW-1:0] HALF_F = PRW'(1) << (F - 1);
  localparam logic [V-1:0]   HI     = {1'b0, {(V-1){1'b1}}};
  localparam logic [V-1:0]   LO     = {1'b1, {(V-1){1'b0}}};

  logic s1, s2, s3, load;

  logic signed [V-1:0]   cen [2], nth [2], sth [2], est [2], wst [2], prv [2];
  logic signed [V-1:0]   ur, uc;
  logic signed [V:0]     dns [2], dew [2];
  logic signed [PRW-1:0] pr [2], pc [2];
  logic signed [V+1:0]   lr [2], lc [2];

  logic signed [PRW-1:0] pr_q [2], pc_q [2];
  logic signed [V+1:0]   lr_q [2], lc_q [2];
  logic signed [V-1:0]   cen1_q [2], prv1_q [2], cen2_q [2], prv2_q [2];
  pt_flags_t             flags1_q, flags2_q, flags3_q;

  logic [PRW-1:0]        rr [2], rc [2];
  logic signed [AW-1:0]  ar [2], ac [2];
  logic signed [TW-1:0]  tar [2], tdr [2], tac [2], tdc [2];
  logic signed [TW-1:0]  tar_q [2], tdr_q [2], tac_q [2], tdc_q [2];

  logic [ACCW-1:0]        rnd;
  logic signed [ACCW-1:0] acc [2], acc_q [2];
  logic signed [RW-1:0]   rs [2];
  logic                   ovf [2];
  logic [V-1:0]           res [2];

  assign op_ready = !(s1 || s2 || s3);
  assign load     = s3 && (!m_tvalid || m_tready);

  // stage 1: neighbor differences, velocity products and second differences
  always_comb begin
    for (int m = 0; m < 2; m++) begin
      cen[m] = $signed(op_ctr[m*V +: V]);
      nth[m] = $signed(op_nth[m*V +: V]);
      sth[m] = $signed(op_sth[m*V +: V]);
      est[m] = $signed(op_est[m*V +: V]);
      wst[m] = $signed(op_wst[m*V +: V]);
      prv[m] = $signed(op_prv[m*V +: V]);
    end
    ur = cen[0];
    uc = cen[1];
    for (int m = 0; m < 2; m++) begin
      dns[m] = (V+1)'(nth[m]) - (V+1)'(sth[m]);
      dew[m] = (V+1)'(est[m]) - (V+1)'(wst[m]);
      pr[m]  = PRW'(ur) * PRW'(dns[m]);
      pc[m]  = PRW'(uc) * PRW'(dew[m]);
      lr[m]  = (V+2)'(nth[m]) + (V+2)'(sth[m]) - ((V+2)'(cen[m]) <<< 1);
      lc[m]  = (V+2)'(est[m]) + (V+2)'(wst[m]) - ((V+2)'(cen[m]) <<< 1);
    end
  end

  // stage 2: rounded advection terms and second differences times coefficients
  always_comb begin
    for (int m = 0; m < 2; m++) begin
      rr[m]  = pr_q[m] + HALF_F;
      rc[m]  = pc_q[m] + HALF_F;
      ar[m]  = $signed(rr[m][PRW-1:F]);
      ac[m]  = $signed(rc[m][PRW-1:F]);
      tar[m] = TW'($signed({1'b0, adv_row})) * TW'(ar[m]);
      tac[m] = TW'($signed({1'b0, adv_col})) * TW'(ac[m]);
      tdr[m] = TW'($signed({1'b0, diff_row})) * TW'(lr_q[m]);
      tdc[m] = TW'($signed({1'b0, diff_col})) * TW'(lc_q[m]);
    end
  end

  // stage 3: accumulate, with the rounding half folded in
  always_comb begin
    rnd = half_weight ? (ACCW'(1) << COEF_BITS) : (ACCW'(1) << (COEF_BITS - 1));
    for (int m = 0; m < 2; m++) begin
      acc[m] = (ACCW'(cen2_q[m]) <<< COEF_BITS)
             - ACCW'(tar_q[m]) + ACCW'(tdr_q[m])
             - ACCW'(tac_q[m]) + ACCW'(tdc_q[m])
             + (half_weight ? (ACCW'(prv2_q[m]) <<< COEF_BITS) : '0)
             + rnd;
    end
  end

  // output: scale back and saturate
  always_comb begin
    for (int m = 0; m < 2; m++) begin
      rs[m]  = half_weight ? RW'(acc_q[m] >>> (COEF_BITS + 1))
                           : RW'(acc_q[m] >>> COEF_BITS);
      ovf[m] = !((&rs[m][RW-1:V-1]) || (~|rs[m][RW-1:V-1]));
      res[m] = ovf[m] ? (rs[m][RW-1] ? LO : HI) : rs[m][V-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      for (int m = 0; m < 2; m++) begin
        pr_q[m]   <= pr[m];
        pc_q[m]   <= pc[m];
        lr_q[m]   <= lr[m];
        lc_q[m]   <= lc[m];
        cen1_q[m] <= cen[m];
        prv1_q[m] <= prv[m];
      end
      flags1_q <= op_flags;
    end
    if (s1) begin
      for (int m = 0; m < 2; m++) begin
        tar_q[m]  <= tar[m];
        tac_q[m]  <= tac[m];
        tdr_q[m]  <= tdr[m];
        tdc_q[m]  <= tdc[m];
        cen2_q[m] <= cen1_q[m];
        prv2_q[m] <= prv1_q[m];
      end
      flags2_q <= flags1_q;
    end
    if (s2) begin
      for (int m = 0; m < 2; m++) begin
        acc_q[m] <= acc[m];
      end
      flags3_q <= flags2_q;
    end
    if (load) begin
      new_row   <= res[0];
      new_col   <= res[1];
      out_flags <= flags3_q;
      saturated <= ovf[0] || ovf[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1       <= 1'b0;
      s2       <= 1'b0;
      s3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      s1 <= op_valid && op_ready;
      s2 <= s1;
      s3 <= s2 || (s3 && !load);
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({s1, s2, s3}))
    else $error("more than one point in the arithmetic stages");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && saturated |->
      (new_row == HI || new_row == LO || new_col == HI || new_col == LO))
    else $error("saturated flag without a clipped component");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    s3 && m_tvalid && !m_tready |=> s3 && m_tvalid)
    else $error("finished result lost while output stalled");

endmodule

FILE: rtl/burgers_stencil_rk2_update.sv
// channel  | direction | handshake          | payload
// s        | in        | s_tvalid/s_tready  | s_tdata: vel_row, vel_col, prev_row, prev_col
//          |           |                    | s_tuser: frame_start
// m        | out       | m_tvalid/m_tready  | m_tdata: new_row, new_col; m_tlast: row_end
//          |           |                    | m_tuser: frame_end, saturated
// cfg      | in        | cfg_we             | cfg_addr register index, cfg_data value
//
// halo-row points are taken without leaving the idle state; an interior point holds off
// the next request for the four reads (center, south, east, west) through the single read
// port of the velocity line memory plus the operand handoff, which waits for op_ready
// the arithmetic runs in a four-stage pipeline behind the reads; a result passes stages
// 1 to 3 and then the output register before it shows on m
// rst is synchronous: it clears the counters, the sequencer, the pipeline valids and
// loads the register defaults; line memories are not cleared
// a stalled result sits in the output register while the next request is read in;
// the next operand handoff waits until the pipeline has drained into that register
module burgers_stencil_rk2_update import bsrk_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request side
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // vel_row, vel_col, prev_row, prev_col from bit 0 up, zero padded
  input  logic [((4*VALUE_BITS+7)/8)*8-1:0] s_tdata,
  // frame_start
  input  logic [0:0]                   s_tuser,
  // result side
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // new_row, new_col from bit 0 up, zero padded
  output logic [((2*VALUE_BITS+7)/8)*8-1:0] m_tdata,
  // row_end
  output logic                         m_tlast,
  // frame_end, saturated from bit 0 up
  output logic [1:0]                   m_tuser,
  // register writes
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int V     = VALUE_BITS;
  localparam int OUT_W = ((2 * VALUE_BITS + 7) / 8) * 8;

  // register file
  logic [15:0]               adv_row, diff_row, adv_col, diff_col;
  logic                      half_weight;
  logic [ROW_WIDTH_BITS-1:0] row_width;
  logic [ROWS_BITS-1:0]      rows_in_use;

  // sequencer to datapath
  logic                      op_valid, op_ready;
  logic [2*V-1:0]            op_ctr, op_nth, op_sth, op_est, op_wst, op_prv;
  pt_flags_t                 op_flags, out_flags;
  logic [V-1:0]              new_row, new_col;
  logic                      saturated;

  always_ff @(posedge clk) begin
    if (rst) begin
      adv_row     <= 16'd8192;
      diff_row    <= 16'd8192;
      adv_col     <= 16'd8192;
      diff_col    <= 16'd8192;
      half_weight <= 1'b0;
      row_width   <= ROW_WIDTH_BITS'(1024);
      rows_in_use <= ROWS_BITS'(256);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ADV_ROW:     adv_row     <= cfg_data;
        REG_DIFF_ROW:    diff_row    <= cfg_data;
        REG_ADV_COL:     adv_col     <= cfg_data;
        REG_DIFF_COL:    diff_col    <= cfg_data;
        REG_HALF_WEIGHT: half_weight <= cfg_data[0];
        REG_ROW_WIDTH:   row_width   <= cfg_data[ROW_WIDTH_BITS-1:0];
        REG_ROWS_IN_USE: rows_in_use <= cfg_data[ROWS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // counters, line memories and the read sequence for the stencil
  bsrk_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .in_vel      (s_tdata[2*V-1:0]),
    .in_prev     (s_tdata[4*V-1:2*V]),
    .frame_start (s_tuser[0]),
    .row_width   (row_width),
    .rows_in_use (rows_in_use),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op_ctr      (op_ctr),
    .op_nth      (op_nth),
    .op_sth      (op_sth),
    .op_est      (op_est),
    .op_wst      (op_wst),
    .op_prv      (op_prv),
    .op_flags    (op_flags)
  );

  // advection/diffusion arithmetic and the output register
  bsrk_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op_ctr      (op_ctr),
    .op_nth      (op_nth),
    .op_sth      (op_sth),
    .op_est      (op_est),
    .op_wst      (op_wst),
    .op_prv      (op_prv),
    .op_flags    (op_flags),
    .adv_row     (adv_row),
    .diff_row    (diff_row),
    .adv_col     (adv_col),
    .diff_col    (diff_col),
    .half_weight (half_weight),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .new_row     (new_row),
    .new_col     (new_col),
    .out_flags   (out_flags),
    .saturated   (saturated)
  );

  assign m_tdata = OUT_W'({new_col, new_row});
  assign m_tlast = out_flags.row_end;
  assign m_tuser = {saturated, out_flags.frame_end};

endmodule
